>>> hw/rtl/vlid_pkg.sv
// Shared types, codes and the opcode class table for the instruction decoder.
// No dependencies.
package vlid_pkg;

    localparam int WORD_W = 16;
    localparam logic [7:0] KNOWN_OPS = 8'd26;

    localparam logic [2:0] FORM_TWO  = 3'd0;
    localparam logic [2:0] FORM_ONE  = 3'd1;
    localparam logic [2:0] FORM_IMM  = 3'd2;
    localparam logic [2:0] FORM_NONE = 3'd3;
    localparam logic [2:0] FORM_INT  = 3'd4;

    localparam logic [2:0] MODE_REG     = 3'd0;
    localparam logic [2:0] MODE_IND     = 3'd1;
    localparam logic [2:0] MODE_ABS     = 3'd2;
    localparam logic [2:0] MODE_SPECIAL = 3'd3;
    localparam logic [2:0] MODE_NONE    = 3'd4;

    typedef struct packed {
        logic        is_data;
        logic [7:0]  opcode;
        logic [2:0]  dest_mode;
        logic [2:0]  dest_reg;
        logic [2:0]  src_mode;
        logic [2:0]  src_reg;
        logic [1:0]  needed;
    } dec_t;

    typedef struct packed {
        logic              is_data;
        logic [7:0]        opcode;
        logic [2:0]        dest_mode;
        logic [2:0]        dest_reg;
        logic [2:0]        src_mode;
        logic [2:0]        src_reg;
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] ext_first;
        logic [WORD_W-1:0] ext_second;
        logic [1:0]        inst_length;
        logic              truncated;
        logic [WORD_W-1:0] start_address;
    } rec_t;

    // operand form of each known opcode
    function automatic logic [2:0] form_of(input logic [4:0] op);
        logic [2:0] f;
        case (op)
            5'd10, 5'd17, 5'd19, 5'd23, 5'd24: f = FORM_NONE;
            5'd12, 5'd13, 5'd14, 5'd15,
            5'd18, 5'd25:                      f = FORM_IMM;
            5'd20, 5'd21:                      f = FORM_ONE;
            5'd22:                             f = FORM_INT;
            default:                           f = FORM_TWO;
        endcase
        return f;
    endfunction

endpackage

>>> hw/rtl/vlid_word_if.sv
// Input channel: one program word per transfer.
// No dependencies.
interface vlid_word_if;
    logic        valid;
    logic        ready;
    logic [15:0] word;
    logic        last_word;

    modport source (output valid, output word, output last_word, input ready);
    modport sink   (input valid, input word, input last_word, output ready);
endinterface

>>> hw/rtl/vlid_rec_if.sv
// Output channel: one decoded instruction record per transfer.
// No dependencies.
interface vlid_rec_if;
    logic        valid;
    logic        ready;
    logic        is_data;
    logic [7:0]  opcode;
    logic [2:0]  dest_mode;
    logic [2:0]  dest_reg;
    logic [2:0]  src_mode;
    logic [2:0]  src_reg;
    logic [15:0] first_word;
    logic [15:0] ext_first;
    logic [15:0] ext_second;
    logic [1:0]  inst_length;
    logic        truncated;
    logic [15:0] start_address;

    modport source (output valid, output is_data, output opcode, output dest_mode,
                    output dest_reg, output src_mode, output src_reg, output first_word,
                    output ext_first, output ext_second, output inst_length,
                    output truncated, output start_address, input ready);
    modport sink   (input valid, input is_data, input opcode, input dest_mode,
                    input dest_reg, input src_mode, input src_reg, input first_word,
                    input ext_first, input ext_second, input inst_length,
                    input truncated, input start_address, output ready);
endinterface

>>> hw/rtl/vlid_decode.sv
// Decodes the first word of an instruction: opcode class, operand modes, length.
// Depends on vlid_pkg.
module vlid_decode
    import vlid_pkg::*;
(
    input  logic [WORD_W-1:0] first,
    output dec_t              dec
);

    logic [2:0] form;
    logic [3:0] dnib;
    logic [3:0] snib;
    logic       dext;
    logic       sext;

    assign dnib = first[7:4];
    assign snib = first[3:0];
    assign form = form_of(first[12:8]);

    always_comb
    begin
        dec           = '0;
        dec.opcode    = first[15:8];
        dec.dest_mode = MODE_NONE;
        dec.src_mode  = MODE_NONE;
        dext          = 1'b0;
        sext          = 1'b0;
        if (first[15:8] >= KNOWN_OPS)
        begin
            dec.is_data = 1'b1;
        end
        else if (form == FORM_TWO || form == FORM_ONE)
        begin
            if (dnib[2:0] != 3'd0)
            begin
                dec.dest_mode = dnib[3] ? MODE_IND : MODE_REG;
                dec.dest_reg  = dnib[2:0] - 3'd1;
            end
            else if (dnib[3])
            begin
                dec.dest_mode = MODE_ABS;
                dext          = 1'b1;
            end
            else
            begin
                dec.dest_mode = MODE_SPECIAL;   // invalid destination, no extra word
            end
            if (form == FORM_TWO)
            begin
                if (snib[2:0] != 3'd0)
                begin
                    dec.src_mode = snib[3] ? MODE_IND : MODE_REG;
                    dec.src_reg  = snib[2:0] - 3'd1;
                end
                else
                begin
                    dec.src_mode = snib[3] ? MODE_ABS : MODE_SPECIAL;
                    sext         = 1'b1;
                end
            end
        end
        else if (form == FORM_IMM)
        begin
            dec.src_mode = MODE_SPECIAL;
            sext         = 1'b1;
        end
        dec.needed = 2'd1 + {1'b0, dext} + {1'b0, sext};
    end

endmodule

>>> hw/rtl/vlid_seq.sv
// Word sequencer: holds a partial instruction, tracks addresses and builds the record.
// Depends on vlid_pkg and vlid_decode.
module vlid_seq
    import vlid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [WORD_W-1:0] word,
    input  logic              last_word,
    output logic              emit,
    output rec_t              rec
);

    logic [WORD_W-1:0] held_first_reg, held_first_next;
    logic [WORD_W-1:0] held_ext_reg, held_ext_next;
    logic [1:0]        needed_reg, needed_next;
    logic [1:0]        held_reg, held_next;
    logic [WORD_W-1:0] addr_reg;

    logic              idle;
    logic [WORD_W-1:0] dec_src;
    dec_t              dec;

    assign idle    = (held_reg == 2'd0) || (held_reg >= needed_reg) || (held_reg > 2'd2);
    assign dec_src = idle ? word : held_first_reg;

    vlid_decode u_decode (
        .first (dec_src),
        .dec   (dec)
    );

    always_comb
    begin
        held_first_next   = held_first_reg;
        held_ext_next     = held_ext_reg;
        needed_next       = needed_reg;
        held_next         = 2'd0;
        emit              = 1'b1;
        rec.is_data       = dec.is_data;
        rec.opcode        = dec.opcode;
        rec.dest_mode     = dec.dest_mode;
        rec.dest_reg      = dec.dest_reg;
        rec.src_mode      = dec.src_mode;
        rec.src_reg       = dec.src_reg;
        rec.first_word    = held_first_reg;
        rec.ext_first     = '0;
        rec.ext_second    = '0;
        rec.inst_length   = 2'd1;
        rec.truncated     = 1'b0;
        rec.start_address = addr_reg - {{(WORD_W-2){1'b0}}, held_reg};
        if (idle)
        begin
            rec.first_word    = word;
            rec.start_address = addr_reg;
            if (dec.needed != 2'd1)
            begin
                held_first_next = word;
                needed_next     = dec.needed;
                rec.truncated   = 1'b1;
                emit            = last_word;
                held_next       = last_word ? 2'd0 : 2'd1;
            end
        end
        else if (held_reg == 2'd1)
        begin
            rec.ext_first   = word;
            rec.inst_length = 2'd2;
            if (needed_reg != 2'd2)
            begin
                held_ext_next = word;
                rec.truncated = 1'b1;
                emit          = last_word;
                held_next     = last_word ? 2'd0 : 2'd2;
            end
        end
        else
        begin
            rec.ext_first   = held_ext_reg;
            rec.ext_second  = word;
            rec.inst_length = 2'd3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg <= 2'd0;
            held_reg   <= 2'd0;
            addr_reg   <= '0;
        end
        else if (accept)
        begin
            needed_reg <= needed_next;
            held_reg   <= held_next;
            addr_reg   <= addr_reg + {{(WORD_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_first_reg <= held_first_next;
            held_ext_reg   <= held_ext_next;
        end
    end

endmodule

>>> hw/rtl/variable_length_instruction_decoder_top.sv
// Variable-length instruction decoder, top level.
// A record appears in the cycle after the word that completes it is taken.
// One word per cycle if not stalled; the output register refills in the cycle it drains.
// Reset clears the pending instruction and the word address to zero.
// Depends on vlid_pkg, vlid_word_if, vlid_rec_if and vlid_seq.
module variable_length_instruction_decoder_top
    import vlid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    vlid_word_if.sink   words,
    vlid_rec_if.source  records
);

    logic accept;
    logic emit;
    rec_t rec;
    rec_t rec_reg;
    logic valid_reg;

    assign words.ready = !valid_reg || records.ready;
    assign accept      = words.valid && words.ready;

    vlid_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (words.word),
        .last_word (words.last_word),
        .emit      (emit),
        .rec       (rec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= emit;
        end
        else if (records.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            rec_reg <= rec;
        end
    end

    assign records.valid         = valid_reg;
    assign records.is_data       = rec_reg.is_data;
    assign records.opcode        = rec_reg.opcode;
    assign records.dest_mode     = rec_reg.dest_mode;
    assign records.dest_reg      = rec_reg.dest_reg;
    assign records.src_mode      = rec_reg.src_mode;
    assign records.src_reg       = rec_reg.src_reg;
    assign records.first_word    = rec_reg.first_word;
    assign records.ext_first     = rec_reg.ext_first;
    assign records.ext_second    = rec_reg.ext_second;
    assign records.inst_length   = rec_reg.inst_length;
    assign records.truncated     = rec_reg.truncated;
    assign records.start_address = rec_reg.start_address;

endmodule
